// ----- sv/dtyp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtyp_pkg
// Shared types, constants and helper functions for the direction to yaw/pitch
// unit.
// ----------------------------------------------------------------------------
package dtyp_pkg;

    localparam int STEP_W     = 5;
    localparam int MAX_STEPS  = 30;
    localparam int CORDIC_W   = 36;
    localparam int ANG_W      = 35;
    localparam int ANGLE_W    = 25;
    localparam int IN_W       = 32;
    localparam int S_DATA_W   = 96;
    localparam int M_DATA_W   = 56;

    localparam logic [ANGLE_W-1:0] TURN_Q16   = 25'd23592960;
    localparam logic [ANGLE_W-1:0] DEG90_Q16  = 25'd5898240;
    localparam logic [ANGLE_W-1:0] DEG180_Q16 = 25'd11796480;
    localparam logic [ANGLE_W-1:0] DEG270_Q16 = 25'd17694720;
    localparam logic signed [ANG_W-1:0] HALF_TURN_Q24 = 35'sd3019898880;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YAW,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_PITCH_INIT,
        ST_PITCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              mul_lo;
        logic              mul_hi;
        logic              pitch_init;
        logic              finish;
        logic [STEP_W-1:0] iter;
    } cmd_t;

    function automatic logic signed [ANG_W-1:0] atan_q24(input logic [STEP_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 35'sd754974720;
            5'd1:  v = 35'sd445687602;
            5'd2:  v = 35'sd235489088;
            5'd3:  v = 35'sd119537938;
            5'd4:  v = 35'sd60000934;
            5'd5:  v = 35'sd30029717;
            5'd6:  v = 35'sd15018523;
            5'd7:  v = 35'sd7509720;
            5'd8:  v = 35'sd3754917;
            5'd9:  v = 35'sd1877466;
            5'd10: v = 35'sd938734;
            5'd11: v = 35'sd469367;
            5'd12: v = 35'sd234684;
            5'd13: v = 35'sd117342;
            5'd14: v = 35'sd58671;
            5'd15: v = 35'sd29335;
            5'd16: v = 35'sd14668;
            5'd17: v = 35'sd7334;
            5'd18: v = 35'sd3667;
            5'd19: v = 35'sd1833;
            5'd20: v = 35'sd917;
            5'd21: v = 35'sd458;
            5'd22: v = 35'sd229;
            5'd23: v = 35'sd115;
            5'd24: v = 35'sd57;
            5'd25: v = 35'sd29;
            5'd26: v = 35'sd14;
            5'd27: v = 35'sd7;
            5'd28: v = 35'sd4;
            5'd29: v = 35'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q.24 degrees -> rounded Q.16, folded into [0, 360)
    function automatic logic [ANGLE_W-1:0] wrap_q16(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] s;
        logic signed [ANG_W-9:0] r;
        logic signed [ANG_W-9:0] turn;
        s    = a + 35'sd128;
        r    = $signed(s[ANG_W-1:8]);
        turn = $signed({2'b00, TURN_Q16});
        if (r < 0)
        begin
            r = r + turn;
        end
        if (r >= turn)
        begin
            r = r - turn;
        end
        return r[ANGLE_W-1:0];
    endfunction

endpackage

// ----- sv/dtyp_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtyp_ctrl
// Sequencer: input handshake, two CORDIC passes, magnitude multiply and the
// output word handshake.
// ----------------------------------------------------------------------------
module dtyp_ctrl #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output dtyp_pkg::cmd_t   cmd
);

    localparam int NSTEPS = (CORDIC_STEPS < dtyp_pkg::MAX_STEPS) ?
                            CORDIC_STEPS : dtyp_pkg::MAX_STEPS;
    localparam logic [dtyp_pkg::STEP_W-1:0] LAST = dtyp_pkg::STEP_W'(NSTEPS - 1);

    dtyp_pkg::state_t state_reg, state_next;
    logic [dtyp_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtyp_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.iter       = cnt_reg;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            dtyp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = dtyp_pkg::ST_YAW;
                end
            end
            dtyp_pkg::ST_YAW:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = dtyp_pkg::ST_MUL_LO;
                end
            end
            dtyp_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = dtyp_pkg::ST_MUL_HI;
            end
            dtyp_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = dtyp_pkg::ST_PITCH_INIT;
            end
            dtyp_pkg::ST_PITCH_INIT:
            begin
                cmd.pitch_init = 1'b1;
                state_next     = dtyp_pkg::ST_PITCH;
            end
            dtyp_pkg::ST_PITCH:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = dtyp_pkg::ST_FINISH;
                end
            end
            dtyp_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = dtyp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtyp_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- sv/dtyp_datapath.sv -----
// ----------------------------------------------------------------------------
// dtyp_datapath
// Shared CORDIC vectoring stage, gain-correction multiplier, angle wrap and
// output register.
// ----------------------------------------------------------------------------
module dtyp_datapath (
    input  logic                            clk,
    input  dtyp_pkg::cmd_t                  cmd,
    input  logic [dtyp_pkg::S_DATA_W-1:0]   s_tdata,
    output logic [dtyp_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int W  = dtyp_pkg::CORDIC_W;
    localparam int AW = dtyp_pkg::ANG_W;
    localparam int OW = dtyp_pkg::ANGLE_W;

    logic signed [W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [AW-1:0] ang_reg, ang_next;
    logic [63:0]          acc_reg, acc_next;
    logic signed [dtyp_pkg::IN_W-1:0] z_reg;
    logic x_zero_reg, y_zero_reg, z_zero_reg, x_pos_reg, y_pos_reg, z_pos_reg;
    logic [OW-1:0] yaw_reg, yaw_next;
    logic [OW-1:0] pitch_out_reg, yaw_out_reg, pitch_next;

    logic signed [dtyp_pkg::IN_W-1:0] in_x, in_y, in_z;
    logic signed [W-1:0]  ext_x, ext_y, dx, dy;
    logic signed [AW-1:0] atan_v;
    logic [16:0]          mul_opnd;
    logic [46:0]          prod;
    logic [63:0]          rnd;

    assign in_x = $signed(s_tdata[31:0]);
    assign in_y = $signed(s_tdata[63:32]);
    assign in_z = $signed(s_tdata[95:64]);
    assign ext_x = W'(in_x);
    assign ext_y = W'(in_y);

    assign dx     = y_reg >>> cmd.iter;
    assign dy     = x_reg >>> cmd.iter;
    assign atan_v = dtyp_pkg::atan_q24(cmd.iter);

    assign mul_opnd = cmd.mul_lo ? x_reg[16:0] : x_reg[33:17];
    assign prod     = 47'(mul_opnd) * 47'(dtyp_pkg::INV_GAIN_Q30);
    assign rnd      = acc_reg + 64'h0000_0000_2000_0000;

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        ang_next = ang_reg;
        acc_next = acc_reg;
        if (cmd.load)
        begin
            if (in_x < 0)
            begin
                x_next   = -ext_x;
                y_next   = -ext_y;
                ang_next = dtyp_pkg::HALF_TURN_Q24;
            end
            else
            begin
                x_next   = ext_x;
                y_next   = ext_y;
                ang_next = '0;
            end
        end
        else if (cmd.step)
        begin
            if (!y_reg[W-1])
            begin
                x_next   = x_reg + dx;
                y_next   = y_reg - dy;
                ang_next = ang_reg + atan_v;
            end
            else
            begin
                x_next   = x_reg - dx;
                y_next   = y_reg + dy;
                ang_next = ang_reg - atan_v;
            end
        end
        else if (cmd.pitch_init)
        begin
            x_next   = $signed({2'b00, rnd[63:30]});
            y_next   = W'(z_reg);
            ang_next = '0;
        end
        if (cmd.mul_lo)
        begin
            acc_next = 64'(prod);
        end
        else if (cmd.mul_hi)
        begin
            acc_next = acc_reg + (64'(prod) << 17);
        end
    end

    always_comb
    begin
        yaw_next = yaw_reg;
        if (cmd.mul_lo)
        begin
            if (x_zero_reg && y_zero_reg)
            begin
                yaw_next = '0;
            end
            else if (y_zero_reg)
            begin
                yaw_next = x_pos_reg ? '0 : dtyp_pkg::DEG180_Q16;
            end
            else if (x_zero_reg)
            begin
                yaw_next = y_pos_reg ? dtyp_pkg::DEG90_Q16 : dtyp_pkg::DEG270_Q16;
            end
            else
            begin
                yaw_next = dtyp_pkg::wrap_q16(ang_reg);
            end
        end
    end

    always_comb
    begin
        if (x_zero_reg && y_zero_reg)
        begin
            pitch_next = z_pos_reg ? dtyp_pkg::DEG270_Q16 : dtyp_pkg::DEG90_Q16;
        end
        else if (z_zero_reg)
        begin
            pitch_next = dtyp_pkg::TURN_Q16;
        end
        else
        begin
            pitch_next = dtyp_pkg::TURN_Q16 - dtyp_pkg::wrap_q16(ang_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
        acc_reg <= acc_next;
        yaw_reg <= yaw_next;
        if (cmd.load)
        begin
            z_reg      <= in_z;
            x_zero_reg <= (in_x == 0);
            y_zero_reg <= (in_y == 0);
            z_zero_reg <= (in_z == 0);
            x_pos_reg  <= (in_x > 0);
            y_pos_reg  <= (in_y > 0);
            z_pos_reg  <= (in_z > 0);
        end
        if (cmd.finish)
        begin
            pitch_out_reg <= pitch_next;
            yaw_out_reg   <= yaw_reg;
        end
    end

    assign m_tdata = {6'b000000, yaw_out_reg, pitch_out_reg};

endmodule

// ----- sv/direction_to_yaw_pitch_unit.sv -----
// ----------------------------------------------------------------------------
// direction_to_yaw_pitch_unit
// Converts a Q16.16 direction vector into yaw and inverted pitch in Q9.16
// degrees using CORDIC vectoring.
// ----------------------------------------------------------------------------
// One word in gives one word out. A new word is taken only in the idle state,
// once the previous word has been through every step: the accepting cycle
// loads the vector, then the yaw and pitch passes run back to back through one
// shared CORDIC iteration stage for min(CORDIC_STEPS, 30) iterations each, with
// the magnitude gain multiply in a low and a high state (split in 17-bit
// halves), a state to seed the pitch pass and a state to register the result.
// The next word is accepted while the previous result waits in the output
// register; it then holds in its last step until that result is taken.
module direction_to_yaw_pitch_unit #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // dir_x[31:0], dir_y[63:32], dir_z[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // pitch_angle[24:0], yaw_angle[49:25], zero pad
);

    dtyp_pkg::cmd_t cmd;

    dtyp_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dtyp_datapath u_datapath (
        .clk     (clk),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule
